>>> rtl/gsa_pkg.sv
// gsa_pkg: shared codes and types for the generational slot allocator.
// Action and status encodings and the controller state type.
// No dependencies.
package gsa_pkg;

  // Width of the request and result fields
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned GEN_W     = 16;
  localparam int unsigned STATUS_W  = 2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FORCE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REQ_DEL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_USED      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

endpackage

>>> rtl/gsa_free_find.sv
// gsa_free_find: priority encoder for the lowest free slot, slot 0 excluded.
// Works on the used-bit vector held by the top level. No package use.
module gsa_free_find #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned IW         = 6
) (
  input  logic [SLOT_COUNT-1:0] used,
  output logic                  found,
  output logic [IW-1:0]         slot
);

  // Scan from the top so the lowest free index wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        slot  = IW'(i);
      end
    end
  end

endmodule

>>> rtl/gsa_slot_mem.sv
// gsa_slot_mem: single-port-write, single-port-read synchronous slot memory.
// Holds the delete mark and generation of each slot. No package use.
module gsa_slot_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 17
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/generational_slot_allocator.sv
// generational_slot_allocator: top level of the generational slot allocator.
// Depends on gsa_pkg, gsa_free_find and gsa_slot_mem.
//
//  channel   handshake                 payload
//  request   start, busy               action, slot_index, generation
//  result    done (one-cycle strobe)   result_slot, result_generation,
//                                      handle_exists, handle_alive,
//                                      newly_marked, status
//
// For each request the accept edge reads the slot memory and captures it, the
// next edge writes it back and registers the result, shown with done for one
// cycle while busy is already low. Busy is high in between, so no new request
// is taken meanwhile. After reset a clearing pass writes zero to all SLOT_COUNT
// memory entries with busy high. The result side cannot stall.
module generational_slot_allocator #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned GEN_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gsa_pkg::ACTION_W-1:0]  action,
  input  logic [gsa_pkg::SLOT_W-1:0]    slot_index,
  input  logic [gsa_pkg::GEN_W-1:0]     generation,
  output logic                          done,
  output logic [gsa_pkg::SLOT_W-1:0]    result_slot,
  output logic [gsa_pkg::GEN_W-1:0]     result_generation,
  output logic                          handle_exists,
  output logic                          handle_alive,
  output logic                          newly_marked,
  output logic [gsa_pkg::STATUS_W-1:0]  status
);

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned DW = GEN_BITS + 1;

  gsa_pkg::ctl_state_t state, state_next;

  // Slot flags kept in flops for the free-slot search
  logic [SLOT_COUNT-1:0] used;
  logic [IW-1:0]         clr_cnt;

  // Captured request
  logic [gsa_pkg::ACTION_W-1:0] req_action;
  logic [gsa_pkg::SLOT_W-1:0]   req_index;
  logic [GEN_BITS-1:0]          req_gen;
  logic [IW-1:0]                req_slot;
  logic                         req_in_range;
  logic                         req_found;

  logic          accept;
  logic          free_found;
  logic [IW-1:0] free_slot;
  logic [IW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // Result and update decisions for the request in flight
  logic                          cur_used;
  logic                          cur_mark;
  logic [GEN_BITS-1:0]           cur_gen;
  logic                          ex;
  logic                          al;
  logic                          set_used;
  logic                          clr_used;
  logic [gsa_pkg::SLOT_W-1:0]    res_slot;
  logic [GEN_BITS-1:0]           res_gen;
  logic                          res_ex;
  logic                          res_al;
  logic                          res_nm;
  logic [gsa_pkg::STATUS_W-1:0]  res_status;

  gsa_free_find #(
    .SLOT_COUNT (SLOT_COUNT),
    .IW         (IW)
  ) u_free_find (
    .used  (used),
    .found (free_found),
    .slot  (free_slot)
  );

  gsa_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IW),
    .DW    (DW)
  ) u_slot_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign accept  = start && !busy;
  assign rd_addr = (action == gsa_pkg::ACT_ALLOC) ? free_slot : IW'(slot_index);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::CTL_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode of the memory word and flags for the captured request
  assign cur_used = used[req_slot];
  assign cur_mark = rd_data[DW-1];
  assign cur_gen  = rd_data[GEN_BITS-1:0];
  assign ex       = cur_used && (cur_gen == req_gen);
  assign al       = ex && !cur_mark;

  // Next state, memory write and result selection
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = req_slot;
    wr_data    = '0;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    res_slot   = req_index;
    res_gen    = '0;
    res_ex     = 1'b0;
    res_al     = 1'b0;
    res_nm     = 1'b0;
    res_status = gsa_pkg::ST_NO_HANDLE;
    unique case (state)
      gsa_pkg::CTL_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        if (clr_cnt == IW'(SLOT_COUNT - 1)) begin
          state_next = gsa_pkg::CTL_IDLE;
        end
      end
      gsa_pkg::CTL_IDLE: begin
        // busy is low here, so start alone means accepted
        busy = 1'b0;
        if (start) begin
          state_next = gsa_pkg::CTL_EXEC;
        end
      end
      gsa_pkg::CTL_EXEC: begin
        state_next = gsa_pkg::CTL_IDLE;
        if (req_action == gsa_pkg::ACT_ALLOC) begin
          if (req_found) begin
            set_used   = 1'b1;
            wr_en      = 1'b1;
            wr_data    = {1'b0, cur_gen};
            res_slot   = gsa_pkg::SLOT_W'(req_slot);
            res_gen    = cur_gen;
            res_status = gsa_pkg::ST_OK;
          end else begin
            res_slot   = '0;
            res_status = gsa_pkg::ST_FULL;
          end
        end else if (req_action > gsa_pkg::ACT_DELETE) begin
          res_slot = '0;
        end else if (req_in_range) begin
          res_ex  = ex;
          res_al  = al;
          res_gen = cur_gen;
          unique case (req_action)
            gsa_pkg::ACT_FORCE: begin
              if (cur_used) begin
                res_status = gsa_pkg::ST_USED;
              end else begin
                set_used   = 1'b1;
                wr_en      = 1'b1;
                wr_data    = {1'b0, req_gen};
                res_gen    = req_gen;
                res_status = gsa_pkg::ST_OK;
              end
            end
            gsa_pkg::ACT_QUERY: begin
              res_status = gsa_pkg::ST_OK;
            end
            gsa_pkg::ACT_REQ_DEL: begin
              if (ex) begin
                res_status = gsa_pkg::ST_OK;
                if (!cur_mark) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, cur_gen};
                  res_nm  = 1'b1;
                end
              end
            end
            default: begin
              // delete: free the slot, keep the mark, advance the generation
              if (ex) begin
                clr_used   = 1'b1;
                wr_en      = 1'b1;
                wr_data    = {cur_mark, cur_gen + GEN_BITS'(1)};
                res_gen    = cur_gen + GEN_BITS'(1);
                res_status = gsa_pkg::ST_OK;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = gsa_pkg::CTL_CLEAR;
      end
    endcase
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == gsa_pkg::CTL_CLEAR) begin
      clr_cnt <= clr_cnt + IW'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action   <= action;
      req_index    <= slot_index;
      req_gen      <= GEN_BITS'(generation);
      req_slot     <= rd_addr;
      req_in_range <= (32'(slot_index) < SLOT_COUNT);
      req_found    <= free_found;
    end
  end

  // Used bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (set_used) begin
      used[req_slot] <= 1'b1;
    end else if (clr_used) begin
      used[req_slot] <= 1'b0;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == gsa_pkg::CTL_EXEC);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == gsa_pkg::CTL_EXEC) begin
      result_slot       <= res_slot;
      result_generation <= gsa_pkg::GEN_W'(res_gen);
      handle_exists     <= res_ex;
      handle_alive      <= res_al;
      newly_marked      <= res_nm;
      status            <= res_status;
    end
  end

endmodule

>>> dv/tb_generational_slot_allocator.sv
// tb_generational_slot_allocator: self-checking bench for the generational slot allocator.
// Models the slot table, drives directed and random requests and checks each result.
// Depends on gsa_pkg and generational_slot_allocator.
module tb_generational_slot_allocator;

  localparam int unsigned SLOTS          = 64;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASES         = 13;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned MAX_GAP        = 14;

  // Action codes past the defined set
  localparam logic [gsa_pkg::ACTION_W-1:0] ACT_UNDEF_FIRST = gsa_pkg::ACT_DELETE + 3'd1;
  localparam logic [gsa_pkg::ACTION_W-1:0] ACT_UNDEF_LAST  = '1;

  typedef enum int { MIX_FILL, MIX_BALANCED, MIX_DRAIN } mix_t;

  // One result, packed in port order
  typedef struct packed {
    logic [gsa_pkg::SLOT_W-1:0]   slot;
    logic [gsa_pkg::GEN_W-1:0]    gen;
    logic                         exists;
    logic                         alive;
    logic                         newly;
    logic [gsa_pkg::STATUS_W-1:0] status;
  } slot_result_t;

  // Slot table model plus the queue of results it still owes
  class handle_book;
    bit                         in_use[SLOTS];
    logic [gsa_pkg::GEN_W-1:0]  gen_of[SLOTS];
    bit                         del_mark[SLOTS];
    slot_result_t               awaiting[$];
    int                         mismatch_count;
    int                         requests, allocs, full_hits, forced, queries;
    int                         first_marks, frees, wraps, undefined;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]   = 1'b0;
        gen_of[i]   = '0;
        del_mark[i] = 1'b0;
      end
    endfunction

    // Apply one accepted request to the table and queue what it must answer
    function void note_request(logic [gsa_pkg::ACTION_W-1:0] act,
                               logic [gsa_pkg::SLOT_W-1:0] idx,
                               logic [gsa_pkg::GEN_W-1:0] gen);
      slot_result_t r;
      bit           hit;
      bit           found;
      r     = '0;
      found = 1'b0;
      hit   = in_use[idx] && gen_of[idx] == gen;
      requests++;
      // handle actions report the flags as they were before the update
      if (act != gsa_pkg::ACT_ALLOC && act <= gsa_pkg::ACT_DELETE) begin
        r.slot   = idx;
        r.gen    = gen_of[idx];
        r.exists = hit;
        r.alive  = hit && !del_mark[idx];
        r.status = gsa_pkg::ST_OK;
      end
      case (act)
        gsa_pkg::ACT_ALLOC: begin
          allocs++;
          for (int i = 1; i < SLOTS; i++) begin
            if (!found && !in_use[i]) begin
              found       = 1'b1;
              in_use[i]   = 1'b1;
              del_mark[i] = 1'b0;
              r.slot      = i[gsa_pkg::SLOT_W-1:0];
              r.gen       = gen_of[i];
            end
          end
          r.status = found ? gsa_pkg::ST_OK : gsa_pkg::ST_FULL;
          if (!found) full_hits++;
        end
        gsa_pkg::ACT_FORCE: begin
          forced++;
          if (in_use[idx]) begin
            r.status = gsa_pkg::ST_USED;
          end else begin
            in_use[idx]   = 1'b1;
            gen_of[idx]   = gen;
            del_mark[idx] = 1'b0;
            r.gen         = gen;
          end
        end
        gsa_pkg::ACT_QUERY: begin
          queries++;
        end
        gsa_pkg::ACT_REQ_DEL: begin
          if (!hit) begin
            r.status = gsa_pkg::ST_NO_HANDLE;
          end else if (!del_mark[idx]) begin
            del_mark[idx] = 1'b1;
            r.newly       = 1'b1;
            first_marks++;
          end
        end
        gsa_pkg::ACT_DELETE: begin
          if (!hit) begin
            r.status = gsa_pkg::ST_NO_HANDLE;
          end else begin
            in_use[idx] = 1'b0;
            gen_of[idx] = gen_of[idx] + 1'b1;
            r.gen       = gen_of[idx];
            frees++;
            if (gen_of[idx] == '0) wraps++;
          end
        end
        default: begin
          r.status = gsa_pkg::ST_NO_HANDLE;
          undefined++;
        end
      endcase
      awaiting.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
    endtask

    // Compare one strobed result against the oldest outstanding prediction
    task check_result(slot_result_t got);
      slot_result_t want;
      if (awaiting.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d gen %0h status %0d",
                                  got.slot, got.gen, got.status));
        return;
      end
      want = awaiting.pop_front();
      if (got.slot != want.slot)
        report_mismatch($sformatf("result_slot %0d, want %0d", got.slot, want.slot));
      if (got.gen != want.gen)
        report_mismatch($sformatf("result_generation %0h, want %0h", got.gen, want.gen));
      if (got.exists != want.exists)
        report_mismatch($sformatf("handle_exists %0b, want %0b", got.exists, want.exists));
      if (got.alive != want.alive)
        report_mismatch($sformatf("handle_alive %0b, want %0b", got.alive, want.alive));
      if (got.newly != want.newly)
        report_mismatch($sformatf("newly_marked %0b, want %0b", got.newly, want.newly));
      if (got.status != want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [gsa_pkg::ACTION_W-1:0] action = gsa_pkg::ACT_QUERY;
  logic [gsa_pkg::SLOT_W-1:0]   slot_index = '0;
  logic [gsa_pkg::GEN_W-1:0]    generation = '0;
  logic                         done;
  logic [gsa_pkg::SLOT_W-1:0]   result_slot;
  logic [gsa_pkg::GEN_W-1:0]    result_generation;
  logic                         handle_exists;
  logic                         handle_alive;
  logic                         newly_marked;
  logic [gsa_pkg::STATUS_W-1:0] status;

  handle_book book = new();
  bit         burst_mode = 1'b0;

  always #2 clk = ~clk;

  generational_slot_allocator u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .slot_index        (slot_index),
    .generation        (generation),
    .done              (done),
    .result_slot       (result_slot),
    .result_generation (result_generation),
    .handle_exists     (handle_exists),
    .handle_alive      (handle_alive),
    .newly_marked      (newly_marked),
    .status            (status)
  );

  // Results are taken at the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (!rst && done)
      book.check_result({result_slot, result_generation, handle_exists, handle_alive,
                         newly_marked, status});
  end

  // Present one request after a random gap, none in burst mode, and hold it until accepted
  task automatic send_request(input logic [gsa_pkg::ACTION_W-1:0] act,
                              input logic [gsa_pkg::SLOT_W-1:0] idx,
                              input logic [gsa_pkg::GEN_W-1:0] gen);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    slot_index <= idx;
    generation <= gen;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_request(act, idx, gen);
  endtask

  // Hold off new requests until every result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (book.awaiting.size() != 0) @(posedge clk);
  endtask

  // Draw a request; delete actions mostly aim at used slots, generations mostly match the table
  task automatic pick_request(input mix_t mix, output logic [gsa_pkg::ACTION_W-1:0] act,
                              output logic [gsa_pkg::SLOT_W-1:0] idx,
                              output logic [gsa_pkg::GEN_W-1:0] gen);
    int cut[5];
    int roll;
    case (mix)
      MIX_FILL:     cut = '{55, 65, 80, 90, 97};
      MIX_DRAIN:    cut = '{10, 15, 30, 60, 97};
      default:      cut = '{25, 35, 55, 75, 97};
    endcase
    roll = $urandom_range(0, 99);
    if (roll < cut[0])      act = gsa_pkg::ACT_ALLOC;
    else if (roll < cut[1]) act = gsa_pkg::ACT_FORCE;
    else if (roll < cut[2]) act = gsa_pkg::ACT_QUERY;
    else if (roll < cut[3]) act = gsa_pkg::ACT_REQ_DEL;
    else if (roll < cut[4]) act = gsa_pkg::ACT_DELETE;
    else act = gsa_pkg::ACTION_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
    idx = gsa_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
    if (act == gsa_pkg::ACT_REQ_DEL || act == gsa_pkg::ACT_DELETE) begin
      for (int k = 0; k < 8 && !book.in_use[idx]; k++)
        idx = gsa_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: gen = book.gen_of[idx];
      6:                gen = book.gen_of[idx] + 1'b1;
      7:                gen = book.gen_of[idx] - 1'b1;
      default:          gen = gsa_pkg::GEN_W'($urandom_range(0, 16'hFFFF));
    endcase
  endtask

  // Ends the run if no handshake happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((!rst && start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [gsa_pkg::ACTION_W-1:0] act;
    logic [gsa_pkg::SLOT_W-1:0]   idx;
    logic [gsa_pkg::GEN_W-1:0]    gen;
    mix_t                         mix;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: lifecycle of one handle, wrap, forced claims, undefined actions
    send_request(gsa_pkg::ACT_ALLOC,   6'd63, 16'hFFFF);
    send_request(gsa_pkg::ACT_QUERY,   6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_QUERY,   6'd1,  16'hFFFF);
    send_request(gsa_pkg::ACT_REQ_DEL, 6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_REQ_DEL, 6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_QUERY,   6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_DELETE,  6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_DELETE,  6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_REQ_DEL, 6'd1,  16'h0000);
    send_request(gsa_pkg::ACT_ALLOC,   6'd0,  16'h0000);
    send_request(gsa_pkg::ACT_QUERY,   6'd1,  16'h0001);
    send_request(gsa_pkg::ACT_FORCE,   6'd0,  16'hFFFF);
    send_request(gsa_pkg::ACT_FORCE,   6'd0,  16'h0000);
    send_request(gsa_pkg::ACT_DELETE,  6'd0,  16'hFFFF);
    send_request(gsa_pkg::ACT_FORCE,   6'd63, 16'h0000);
    send_request(gsa_pkg::ACT_QUERY,   6'd63, 16'hFFFF);
    send_request(gsa_pkg::ACT_ALLOC,   6'd21, 16'h5AA5);
    send_request(ACT_UNDEF_FIRST,      6'd63, 16'hFFFF);
    send_request(ACT_UNDEF_LAST,       6'd42, 16'hA55A);
    send_request(gsa_pkg::ACT_QUERY,   6'd0,  16'h0000);
    send_request(gsa_pkg::ACT_DELETE,  6'd63, 16'h0000);
    send_request(gsa_pkg::ACT_FORCE,   6'd63, 16'h5AA5);
    wait_drained();

    // Random phases: fill, mixed and drain, some back to back
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      burst_mode = (ph % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_request(mix, act, idx, gen);
        send_request(act, idx, gen);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d requests: %0d allocations (%0d on a full table), %0d forced, %0d queries",
             book.requests, book.allocs, book.full_hits, book.forced,
             book.queries);
    $display("  %0d first delete marks, %0d frees (%0d generation wraps), %0d undefined actions",
             book.first_marks, book.frees, book.wraps, book.undefined);
    if (book.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
